// ===== hdl/lslc_pkg.sv =====
// ----------------------------------------------------------------------------
// lslc_pkg
// constants, types and helpers for the light sensor lux calculator
// ----------------------------------------------------------------------------
package lslc_pkg;

  localparam int CNT_W       = 16;
  localparam int SCALE_W     = 19;
  localparam int SCALE_FRAC  = 10;
  localparam int CH_W        = CNT_W + SCALE_W - SCALE_FRAC;
  localparam int RATIO_FRAC  = 10;
  localparam int THR_W       = 11;
  localparam int COEF_W      = 10;
  localparam int NUM_W       = CH_W + RATIO_FRAC + 1;
  localparam int PROD_W      = CH_W + COEF_W;
  localparam int LUX_W       = 21;
  localparam int LUX_FRAC    = 14;
  localparam int BAND_COUNT  = 7;

  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [CH_W-1:0]    ch_t;
  typedef logic [THR_W-1:0]   thr_t;
  typedef logic [COEF_W-1:0]  coef_t;
  typedef logic [PROD_W-1:0]  prod_t;

  localparam logic [1:0] IT_SHORT  = 2'd0;
  localparam logic [1:0] IT_MEDIUM = 2'd1;

  localparam scale_t SCALE_SHORT   = scale_t'(16'h7517);
  localparam scale_t SCALE_MEDIUM  = scale_t'(16'h0FE7);
  localparam scale_t SCALE_NOMINAL = scale_t'(1 << SCALE_FRAC);

  // rounded ratio <= k  <=>  ch1 * 1024 < (2k + 1) * ch0
  localparam thr_t BAND_THR [BAND_COUNT] = '{
    thr_t'(2 * 'h043 + 1), thr_t'(2 * 'h085 + 1), thr_t'(2 * 'h0c8 + 1),
    thr_t'(2 * 'h10a + 1), thr_t'(2 * 'h14d + 1), thr_t'(2 * 'h19a + 1),
    thr_t'(2 * 'h29a + 1)
  };
  localparam coef_t BAND_B [BAND_COUNT] = '{
    coef_t'('h204), coef_t'('h228), coef_t'('h253), coef_t'('h282),
    coef_t'('h177), coef_t'('h101), coef_t'('h037)
  };
  localparam coef_t BAND_M [BAND_COUNT] = '{
    coef_t'('h1ad), coef_t'('h2c1), coef_t'('h363), coef_t'('h3df),
    coef_t'('h1dd), coef_t'('h127), coef_t'('h02b)
  };

  function automatic scale_t scale_for(input logic [1:0] itime, input logic hgain);
    scale_t s;
    unique case (itime)
      IT_SHORT:  s = SCALE_SHORT;
      IT_MEDIUM: s = SCALE_MEDIUM;
      default:   s = SCALE_NOMINAL;
    endcase
    if (!hgain) begin
      s = s << 4;
    end
    return s;
  endfunction

endpackage

// ===== hdl/light_sensor_lux_calc_top.sv =====
// ----------------------------------------------------------------------------
// light_sensor_lux_calc_top
// lux from broadband and infrared photodiode counts, five stage pipeline
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries broadband_count and
//   infrared_count; each accepted item gives exactly one lux item on the
//   output channel out_valid / out_stall, in order.
//   An item passes through five register stages: channel scaling
//   multipliers, band threshold multipliers, band compare and coefficient
//   select, coefficient multipliers, difference with rounding into the
//   output register. One item can be accepted every cycle while in_stall
//   is low; throughput is then one item per cycle.
//   When the receiver stalls, the output item holds; earlier stages keep
//   filling empty slots, and in_stall rises only once every stage is full.
//   Synchronous reset empties the pipeline and sets integration_time to 0
//   and gain_x16 to 1. The APB port writes those two registers at byte
//   addresses 0 and 4 and reads them back; write only while idle.
// ----------------------------------------------------------------------------
module light_sensor_lux_calc_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lslc_pkg::CNT_W-1:0]  broadband_count,
  input  logic [lslc_pkg::CNT_W-1:0]  infrared_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lslc_pkg::LUX_W-1:0]  lux
);
  import lslc_pkg::*;

  logic [1:0] integration_time;
  logic       gain_x16;

  // stage registers
  logic  v1, v2, v3, v4, v5;
  ch_t   ch0_1, ch1_1, ch0_2, ch1_2, ch0_3, ch1_3;
  logic  zero2;
  logic [NUM_W-1:0] thr2 [BAND_COUNT];
  coef_t b3, m3;
  prod_t pos4, neg4;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  scale_t              scale;
  logic [CNT_W+SCALE_W-1:0] raw0_p, raw1_p;
  logic [NUM_W-1:0]    num2;
  coef_t               b_sel, m_sel;
  prod_t               diff;
  logic [PROD_W:0]     rsum;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_time <= IT_SHORT;
      gain_x16         <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        gain_x16 <= pwdata[0];
      end else begin
        integration_time <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {31'b0, gain_x16};
    end else begin
      prdata = {30'b0, integration_time};
    end
  end

  // flow control
  assign rdy5     = !v5 || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: scale both channels
  assign scale  = scale_for(integration_time, gain_x16);
  assign raw0_p = {{SCALE_W{1'b0}}, broadband_count} * {{CNT_W{1'b0}}, scale};
  assign raw1_p = {{SCALE_W{1'b0}}, infrared_count} * {{CNT_W{1'b0}}, scale};

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ch0_1 <= raw0_p[SCALE_FRAC +: CH_W];
      ch1_1 <= raw1_p[SCALE_FRAC +: CH_W];
    end
  end

  // stage 2: band thresholds scaled by ch0
  always_ff @(posedge clk) begin
    if (rdy2) begin
      ch0_2 <= ch0_1;
      ch1_2 <= ch1_1;
      zero2 <= (ch0_1 == '0);
      for (int i = 0; i < BAND_COUNT; i++) begin
        thr2[i] <= {{(NUM_W-CH_W){1'b0}}, ch0_1} *
                   {{(NUM_W-THR_W){1'b0}}, BAND_THR[i]};
      end
    end
  end

  // stage 3: band select
  assign num2 = {1'b0, ch1_2, {RATIO_FRAC{1'b0}}};

  always_comb begin
    b_sel = '0;
    m_sel = '0;
    for (int i = BAND_COUNT - 1; i >= 0; i--) begin
      if (num2 < thr2[i]) begin
        b_sel = BAND_B[i];
        m_sel = BAND_M[i];
      end
    end
    if (zero2) begin
      b_sel = BAND_B[0];
      m_sel = BAND_M[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ch0_3 <= ch0_2;
      ch1_3 <= ch1_2;
      b3    <= b_sel;
      m3    <= m_sel;
    end
  end

  // stage 4: coefficient products
  always_ff @(posedge clk) begin
    if (rdy4) begin
      pos4 <= {{COEF_W{1'b0}}, ch0_3} * {{CH_W{1'b0}}, b3};
      neg4 <= {{COEF_W{1'b0}}, ch1_3} * {{CH_W{1'b0}}, m3};
    end
  end

  // stage 5: clamp, round, shift
  assign diff = (pos4 > neg4) ? (pos4 - neg4) : '0;
  assign rsum = {1'b0, diff} + ((PROD_W+1)'(1) << (LUX_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rdy5) begin
      lux <= rsum[LUX_FRAC +: LUX_W];
    end
  end

  assign out_valid = v5;

endmodule

// ===== hdl/lslc_checker.sv =====
// ----------------------------------------------------------------------------
// lslc_checker
// port level checks for the lux calculator, bound to the top level
// ----------------------------------------------------------------------------
module lslc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] lux
);

  // stalled output item stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(lux))
    else $error("lux changed while stalled");

  // backpressure only comes from a full pipeline behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind light_sensor_lux_calc_top lslc_checker u_lslc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .lux       (lux)
);

// ===== bench/light_sensor_lux_calc_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_lux_calc_top_tb
// self-checking bench for the light sensor lux calculator
// ----------------------------------------------------------------------------
// Readings go in on the valid/stall input channel while a random sink stalls
// the lux channel. Every accepted reading is turned into an expected lux
// value by an independent model of the band formula, using the integration
// time and gain last written over the register port. Each lux item must
// match the oldest expected value. A short directed pass covers count
// extremes and both sides of every band edge. Random passes then run under
// all integration time and gain settings.
// ----------------------------------------------------------------------------
module light_sensor_lux_calc_top_tb;
  import lslc_pkg::*;

  localparam logic [2:0] REG_INTEGRATION_TIME = 3'd0;
  localparam logic [2:0] REG_GAIN_X16         = 3'd4;
  localparam int         PHASE_ITEMS          = 190;

  class lux_scoreboard;
    logic [1:0]       itime  = IT_SHORT;
    logic             hgain  = 1'b1;
    int unsigned      errors = 0;
    logic [LUX_W-1:0] expected_lux [$];

    function void set_config(logic [1:0] it, logic hg);
      itime = it;
      hgain = hg;
    endfunction

    function void note_reading(logic [CNT_W-1:0] bb, logic [CNT_W-1:0] ir);
      bit [63:0] scale, ch0, ch1, ratio, rnd, pos, neg, diff, b, m;
      if (itime == IT_SHORT) scale = 64'h7517;
      else if (itime == IT_MEDIUM) scale = 64'h0FE7;
      else scale = 64'd1024;
      if (!hgain) scale = scale << 4;
      ch0 = (64'(bb) * scale) >> 10;
      ch1 = (64'(ir) * scale) >> 10;
      ratio = (ch0 != 0) ? (ch1 << 10) / ch0 : 64'd0;
      rnd = (ratio + 1) >> 1;
      if (rnd <= 64'h043) begin
        b = 64'h204; m = 64'h1ad;
      end else if (rnd <= 64'h085) begin
        b = 64'h228; m = 64'h2c1;
      end else if (rnd <= 64'h0c8) begin
        b = 64'h253; m = 64'h363;
      end else if (rnd <= 64'h10a) begin
        b = 64'h282; m = 64'h3df;
      end else if (rnd <= 64'h14d) begin
        b = 64'h177; m = 64'h1dd;
      end else if (rnd <= 64'h19a) begin
        b = 64'h101; m = 64'h127;
      end else if (rnd <= 64'h29a) begin
        b = 64'h037; m = 64'h02b;
      end else begin
        b = 0; m = 0;
      end
      pos = ch0 * b;
      neg = ch1 * m;
      diff = (pos > neg) ? pos - neg : 64'd0;
      expected_lux.push_back(LUX_W'((diff + 64'd8192) >> 14));
    endfunction

    function void check_lux(logic [LUX_W-1:0] got);
      logic [LUX_W-1:0] want;
      if (expected_lux.size() == 0) begin
        $display("%0t: unexpected lux item, actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_lux.pop_front();
        if (got !== want) begin
          $display("%0t: lux mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_lux.size();
    endfunction
  endclass

  logic             clk             = 1'b0;
  logic             rst             = 1'b1;
  logic             psel            = 1'b0;
  logic             penable         = 1'b0;
  logic             pwrite          = 1'b0;
  logic [2:0]       paddr           = '0;
  logic [31:0]      pwdata          = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] broadband_count = '0;
  logic [CNT_W-1:0] infrared_count  = '0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [LUX_W-1:0] lux;
  bit               quiet           = 1'b0;

  lux_scoreboard sb = new();

  light_sensor_lux_calc_top dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .broadband_count (broadband_count),
    .infrared_count  (infrared_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .lux             (lux)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_reading(broadband_count, infrared_count);
    if (!rst && out_valid && !out_stall) sb.check_lux(lux);
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input logic [1:0] it, input logic hg);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    reg_write(REG_INTEGRATION_TIME, 32'(it));
    reg_write(REG_GAIN_X16, 32'(hg));
    sb.set_config(it, hg);
  endtask

  // entered and left at a falling edge
  task automatic send_reading(input logic [CNT_W-1:0] bb, input logic [CNT_W-1:0] ir);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    broadband_count <= bb;
    infrared_count  <= ir;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [CNT_W-1:0] edge_count();
    case ($urandom_range(3))
      0: return '0;
      1: return CNT_W'(1);
      2: return '1;
      default: return CNT_W'($urandom);
    endcase
  endfunction

  task automatic send_random_reading();
    logic [CNT_W-1:0] bb, ir;
    int unsigned      pick, ratio, scaled;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // ratio spread over all bands and a little above the top one
      bb     = CNT_W'($urandom_range(65535) >> $urandom_range(15));
      ratio  = $urandom_range(1450);
      scaled = (32'(bb) * ratio) >> 10;
      ir     = (scaled > 65535) ? '1 : CNT_W'(scaled);
    end else if (pick < 80) begin
      bb = CNT_W'($urandom);
      ir = CNT_W'($urandom);
    end else if (pick < 90) begin
      bb = CNT_W'($urandom_range(63));
      ir = CNT_W'($urandom_range(63));
    end else begin
      bb = edge_count();
      ir = edge_count();
    end
    send_reading(bb, ir);
  endtask

  initial begin
    int unsigned band_top [7] = '{'h043, 'h085, 'h0c8, 'h10a, 'h14d, 'h19a, 'h29a};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // count extremes under the reset setting
    send_reading(16'd0, 16'd0);
    send_reading(16'hffff, 16'hffff);
    send_reading(16'hffff, 16'd0);
    send_reading(16'd0, 16'hffff);
    send_reading(16'd1, 16'd0);
    send_reading(16'd1, 16'hffff);
    send_reading(16'hffff, 16'd1);

    // nominal scale: channel counts pass unchanged, so band edges are exact
    apply_setting(2'd2, 1'b1);
    for (int i = 0; i < 7; i++) begin
      send_reading(16'd1024, CNT_W'(2 * band_top[i]));
      send_reading(16'd1024, CNT_W'(2 * band_top[i] + 1));
    end

    for (int p = 0; p < 8; p++) begin
      apply_setting(2'(p >> 1), ~p[0]);
      quiet = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_reading();
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("light_sensor_lux_calc_top regression: pass");
    end else begin
      $display("light_sensor_lux_calc_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("light_sensor_lux_calc_top regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lslc_pkg.sv
hdl/light_sensor_lux_calc_top.sv
hdl/lslc_checker.sv
bench/light_sensor_lux_calc_top_tb.sv
